// ===== sv/h2st_pkg.sv =====
// Package with shared types and constants for the half-to-single transpose block.
`default_nettype none

package h2st_pkg;

    localparam int unsigned MAX_DIM  = 4096;
    localparam int unsigned DIM_W    = 13;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned INDEX_W  = 24;
    localparam int unsigned HALF_W   = 16;
    localparam int unsigned SINGLE_W = 32;

    typedef logic [DIM_W-1:0]    dim_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [INDEX_W-1:0]  index_t;
    typedef logic [HALF_W-1:0]   half_t;
    typedef logic [SINGLE_W-1:0] single_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic       valid;
        cfg_index_t index;
        dim_t       data;
    } cfg_write_t;

    typedef struct packed {
        logic advance;
        logic start;
    } step_t;

endpackage

`default_nettype wire

// ===== sv/h2st_if.sv =====
// Stream and configuration channel interfaces.
`default_nettype none

interface h2st_in_if;
    logic                 valid;
    logic                 ready;
    h2st_pkg::half_t      half_bits;
    logic                 start_of_matrix;

    modport source (output valid, output half_bits, output start_of_matrix, input ready);
    modport sink   (input valid, input half_bits, input start_of_matrix, output ready);
endinterface

interface h2st_out_if;
    logic                 valid;
    logic                 ready;
    h2st_pkg::single_t    single_bits;
    h2st_pkg::index_t     dest_index;
    logic                 last_element;

    modport source (output valid, output single_bits, output dest_index,
                    output last_element, input ready);
    modport sink   (input valid, input single_bits, input dest_index,
                    input last_element, output ready);
endinterface

interface h2st_cfg_if;
    logic                    valid;
    logic                    ready;
    h2st_pkg::cfg_index_t    index;
    h2st_pkg::dim_t          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/h2st_convert.sv =====
// Binary16 to binary32 format conversion, combinational.
`default_nettype none

module h2st_convert
(
    input  h2st_pkg::half_t   half_bits,
    output h2st_pkg::single_t single_bits
);

    logic        sign;
    logic [4:0]  expo;
    logic [9:0]  mant;
    logic [3:0]  msb;
    logic [3:0]  shifts;
    logic [9:0]  norm;
    logic [7:0]  sub_expo;

    assign sign = half_bits[15];
    assign expo = half_bits[14:10];
    assign mant = half_bits[9:0];

    // Find the leading one of a subnormal mantissa
    always_comb
    begin
        msb = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (mant[i])
            begin
                msb = 4'(i);
            end
        end
    end

    // Shift the leading one out past the top bit; what remains is the fraction
    assign shifts   = 4'd10 - msb;
    assign norm     = mant << shifts;
    assign sub_expo = 8'd103 + {4'd0, msb};

    always_comb
    begin
        if (expo == 5'd0)
        begin
            if (mant == 10'd0)
            begin
                single_bits = {sign, 31'd0};
            end
            else
            begin
                single_bits = {sign, sub_expo, norm, 13'd0};
            end
        end
        else if (expo == 5'h1F)
        begin
            single_bits = {sign, 8'hFF, mant, 13'd0};
        end
        else
        begin
            single_bits = {sign, 8'({3'd0, expo} + 8'd112), mant, 13'd0};
        end
    end

endmodule

`default_nettype wire

// ===== sv/h2st_index.sv =====
// Dimension registers and row/column counters that produce the transposed index.
`default_nettype none

module h2st_index
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  h2st_pkg::cfg_write_t cfg_write,
    input  h2st_pkg::step_t      step,
    output h2st_pkg::index_t     dest_index,
    output logic                 last_element
);

    h2st_pkg::dim_t row_count_reg;
    h2st_pkg::dim_t col_count_reg;
    h2st_pkg::pos_t row_pos_reg;
    h2st_pkg::pos_t row_pos_next;
    h2st_pkg::pos_t col_pos_reg;
    h2st_pkg::pos_t col_pos_next;

    h2st_pkg::dim_t rows;
    h2st_pkg::dim_t cols;
    h2st_pkg::pos_t row_cur;
    h2st_pkg::pos_t col_cur;
    logic [h2st_pkg::POS_W+h2st_pkg::DIM_W-1:0] product;
    logic           row_end;

    // Clamp dimensions into 1..MAX_DIM
    always_comb
    begin
        priority if (row_count_reg == '0)
            rows = h2st_pkg::DIM_W'(1);
        else if (row_count_reg > h2st_pkg::DIM_W'(h2st_pkg::MAX_DIM))
            rows = h2st_pkg::DIM_W'(h2st_pkg::MAX_DIM);
        else
            rows = row_count_reg;

        priority if (col_count_reg == '0)
            cols = h2st_pkg::DIM_W'(1);
        else if (col_count_reg > h2st_pkg::DIM_W'(h2st_pkg::MAX_DIM))
            cols = h2st_pkg::DIM_W'(h2st_pkg::MAX_DIM);
        else
            cols = col_count_reg;
    end

    assign row_cur = step.start ? '0 : row_pos_reg;
    assign col_cur = step.start ? '0 : col_pos_reg;

    assign product    = {13'd0, col_cur} * {12'd0, rows};
    assign dest_index = h2st_pkg::INDEX_W'(product + {13'd0, row_cur});

    assign row_end      = {1'b0, col_cur} >= (cols - h2st_pkg::DIM_W'(1));
    assign last_element = row_end && ({1'b0, row_cur} >= (rows - h2st_pkg::DIM_W'(1)));

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (step.advance)
        begin
            priority if (last_element)
            begin
                row_pos_next = '0;
                col_pos_next = '0;
            end
            else if (row_end)
            begin
                row_pos_next = row_cur + h2st_pkg::POS_W'(1);
                col_pos_next = '0;
            end
            else
            begin
                row_pos_next = row_cur;
                col_pos_next = col_cur + h2st_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            row_count_reg <= h2st_pkg::DIM_W'(1);
            col_count_reg <= h2st_pkg::DIM_W'(1);
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            if (cfg_write.valid)
            begin
                unique case (cfg_write.index)
                    h2st_pkg::REG_ROW_COUNT: row_count_reg <= cfg_write.data;
                    h2st_pkg::REG_COL_COUNT: col_count_reg <= cfg_write.data;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/half_to_single_transpose.sv =====
// Top level: half-to-single conversion with transposed destination index.
//
// Usage:
//   halves  - input stream, one binary16 word per handshake plus a
//             start_of_matrix flag that restarts the row/column counters.
//   singles - output stream, one binary32 word per input word with its
//             index in the transposed [cols][rows] layout (col*rows+row)
//             and a last_element flag on the word that closes the matrix.
//   cfg     - register write channel, always ready. Index REG_ROW_COUNT and
//             REG_COL_COUNT set the matrix size; write only while idle.
//   A word accepted on halves is registered and offered on singles in the
//   next cycle. Throughput is one word per cycle unless singles stalls,
//   set by the single output register, which is loaded whenever it is
//   empty or being drained. When the receiver stalls, the output register
//   holds its word and the input ready drops until the word is taken.
//   Reset clears the counters to row 0, column 0, sets both dimensions to 1
//   and empties the output register.
// After the last word of a matrix the counters wrap, so the next matrix may
// follow without a start flag.
`default_nettype none

module half_to_single_transpose
(
    input  logic       clk,
    input  logic       rst_n,
    h2st_in_if.sink    halves,
    h2st_out_if.source singles,
    h2st_cfg_if.sink   cfg
);

    logic                 in_accept;
    h2st_pkg::cfg_write_t cfg_write;
    h2st_pkg::step_t      step;
    h2st_pkg::single_t    conv_bits;
    h2st_pkg::index_t     dest_index;
    logic                 last_element;

    logic                 out_valid_reg;
    h2st_pkg::single_t    single_bits_reg;
    h2st_pkg::index_t     dest_index_reg;
    logic                 last_element_reg;

    // Take a new word whenever the output register is empty or being drained
    assign halves.ready = !out_valid_reg || singles.ready;
    assign in_accept    = halves.valid && halves.ready;

    assign cfg.ready       = 1'b1;
    assign cfg_write.valid = cfg.valid;
    assign cfg_write.index = cfg.index;
    assign cfg_write.data  = cfg.data;

    assign step.advance = in_accept;
    assign step.start   = halves.start_of_matrix;

    h2st_convert u_convert
    (
        .half_bits   (halves.half_bits),
        .single_bits (conv_bits)
    );

    h2st_index u_index
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .step         (step),
        .dest_index   (dest_index),
        .last_element (last_element)
    );

    // Output register: fill on accept, drop when taken with nothing behind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (singles.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            single_bits_reg  <= conv_bits;
            dest_index_reg   <= dest_index;
            last_element_reg <= last_element;
        end
    end

    assign singles.valid        = out_valid_reg;
    assign singles.single_bits  = single_bits_reg;
    assign singles.dest_index   = dest_index_reg;
    assign singles.last_element = last_element_reg;

`ifndef NO_ASSERTIONS
    a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> singles.valid)
        else $error("accepted word did not reach the output register");

    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !singles.valid |-> halves.ready)
        else $error("input stalled while output register is empty");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !halves.ready |-> (singles.valid && !singles.ready))
        else $error("input stalled without a blocked output word");
`endif

endmodule

`default_nettype wire
